FILE: design/track_health_supervisor_defines.svh
// assertion helpers for the track health supervisor
`ifndef TRACK_HEALTH_SUPERVISOR_DEFINES_SVH
`define TRACK_HEALTH_SUPERVISOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define THS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define THS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ths_pkg.sv
`timescale 1ns / 1ps
package ths_pkg;

   localparam int ScoreW  = 16;
   localparam int SimW    = 16;
   localparam int CountW  = 8;
   localparam int LostW   = 16;
   localparam int StateW  = 2;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 16;

   localparam logic [ScoreW-1:0]      ScoreThrReset  = 16'd2048;
   localparam logic [CountW-1:0]      PatienceReset  = 8'd5;
   localparam logic [CountW-1:0]      DriftPerReset  = 8'd0;
   localparam logic signed [SimW-1:0] DriftThrReset  = 16'sd6554;
   localparam logic [CountW-1:0]      DetectPerReset = 8'd5;
   localparam logic                   ReacqEnReset   = 1'b0;

   localparam logic [CountW-1:0] CountMax = '1;
   localparam logic [LostW-1:0]  LostMax  = '1;

   typedef enum logic [StateW-1:0] {
      TRK_TRACKING = 2'd0,
      TRK_UNSTABLE = 2'd1,
      TRK_LOST     = 2'd2
   } ths_track_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_SCORE_THRESHOLD  = 3'd0,
      REG_LOSS_PATIENCE    = 3'd1,
      REG_DRIFT_PERIOD     = 3'd2,
      REG_DRIFT_THRESHOLD  = 3'd3,
      REG_DETECT_PERIOD    = 3'd4,
      REG_REACQUIRE_ENABLE = 3'd5
   } ths_reg_type;

   typedef struct packed {
      logic [ScoreW-1:0]      score_threshold;
      logic [CountW-1:0]      loss_patience;
      logic [CountW-1:0]      drift_period;
      logic signed [SimW-1:0] drift_threshold;
      logic [CountW-1:0]      detect_period;
      logic                   reacquire_enable;
   } ths_cfg_type;

   typedef struct packed {
      logic [StateW-1:0] track_state;
      logic              drift_checked;
      logic              drift_failed;
      logic              attempt_made;
      logic              relocked;
      logic [LostW-1:0]  lost_count;
   } ths_rsp_type;

endpackage

FILE: design/ths_if.sv
`timescale 1ns / 1ps
interface ths_req_if;
   import ths_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ScoreW-1:0]      score;
   logic signed [SimW-1:0] similarity;
   logic                   candidate_found;

   modport source (output valid, score, similarity, candidate_found, input ready);
   modport sink   (input valid, score, similarity, candidate_found, output ready);
endinterface

interface ths_rsp_if;
   import ths_pkg::*;
   logic              valid;
   logic              ready;
   logic [StateW-1:0] track_state;
   logic              drift_checked;
   logic              drift_failed;
   logic              attempt_made;
   logic              relocked;
   logic [LostW-1:0]  lost_count;

   modport source (output valid, track_state, drift_checked, drift_failed, attempt_made,
                   relocked, lost_count, input ready);
   modport sink   (input valid, track_state, drift_checked, drift_failed, attempt_made,
                   relocked, lost_count, output ready);
endinterface

interface ths_csr_if;
   import ths_pkg::*;
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [CsrDatW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/ths_csr.sv
`timescale 1ns / 1ps
module ths_csr import ths_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [CsrIdxW-1:0] wr_index,
   input  logic [CsrDatW-1:0] wr_data,
   output ths_cfg_type        cfg
);

   ths_cfg_type cfg_ff;
   ths_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (ths_reg_type'(wr_index))
            REG_SCORE_THRESHOLD:  cfg_in.score_threshold  = wr_data[ScoreW-1:0];
            REG_LOSS_PATIENCE:    cfg_in.loss_patience    = wr_data[CountW-1:0];
            REG_DRIFT_PERIOD:     cfg_in.drift_period     = wr_data[CountW-1:0];
            REG_DRIFT_THRESHOLD:  cfg_in.drift_threshold  = $signed(wr_data[SimW-1:0]);
            REG_DETECT_PERIOD:    cfg_in.detect_period    = wr_data[CountW-1:0];
            REG_REACQUIRE_ENABLE: cfg_in.reacquire_enable = wr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold  <= ScoreThrReset;
         cfg_ff.loss_patience    <= PatienceReset;
         cfg_ff.drift_period     <= DriftPerReset;
         cfg_ff.drift_threshold  <= DriftThrReset;
         cfg_ff.detect_period    <= DetectPerReset;
         cfg_ff.reacquire_enable <= ReacqEnReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/ths_core.sv
`timescale 1ns / 1ps
module ths_core import ths_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ths_cfg_type            cfg,
   input  logic                   step,
   input  logic [ScoreW-1:0]      score,
   input  logic signed [SimW-1:0] similarity,
   input  logic                   candidate_found,
   output ths_rsp_type            result
);

   logic [CountW-1:0] low_run_ff, low_run_in;
   logic [CountW-1:0] check_counter_ff, check_counter_in;
   logic              drift_latch_ff, drift_latch_in;
   logic [LostW-1:0]  lost_frames_ff, lost_frames_in;
   logic [CountW-1:0] attempt_phase_ff, attempt_phase_in;

   logic [CountW-1:0] pat;
   logic [CountW-1:0] det_per;
   logic [CountW:0]   phase_inc;
   logic              due;
   ths_track_type     st;
   ths_rsp_type       res;

   always_comb begin
      pat       = (cfg.loss_patience == '0) ? CountW'(1) : cfg.loss_patience;
      det_per   = (cfg.detect_period == '0) ? CountW'(1) : cfg.detect_period;
      phase_inc = {1'b0, attempt_phase_ff} + (CountW+1)'(1);
      due       = 1'b0;

      low_run_in       = low_run_ff;
      check_counter_in = check_counter_ff;
      drift_latch_in   = drift_latch_ff;
      lost_frames_in   = lost_frames_ff;
      attempt_phase_in = attempt_phase_ff;
      res              = '0;

      // low-score run
      if (score < cfg.score_threshold) begin
         if (low_run_ff != CountMax) begin
            low_run_in = low_run_ff + CountW'(1);
         end
      end else begin
         low_run_in = '0;
      end
      if (low_run_in == '0) begin
         st = TRK_TRACKING;
      end else if (low_run_in >= pat) begin
         st = TRK_LOST;
      end else begin
         st = TRK_UNSTABLE;
      end

      // periodic drift check, every tracking frame while latched
      if (st == TRK_TRACKING) begin
         if (cfg.drift_period != '0) begin
            if (drift_latch_ff) begin
               due = 1'b1;
            end else begin
               if (check_counter_ff != CountMax) begin
                  check_counter_in = check_counter_ff + CountW'(1);
               end
               due = (check_counter_in >= cfg.drift_period);
            end
         end
         if (due) begin
            res.drift_checked = 1'b1;
            check_counter_in  = '0;
            if (similarity >= cfg.drift_threshold) begin
               drift_latch_in = 1'b0;
            end else begin
               drift_latch_in   = 1'b1;
               res.drift_failed = 1'b1;
               low_run_in       = pat;
               st               = TRK_LOST;
            end
         end
         if (st == TRK_TRACKING) begin
            lost_frames_in   = '0;
            attempt_phase_in = '0;
         end
      end

      // re-acquisition attempts while lost and enabled
      if (st == TRK_LOST && cfg.reacquire_enable) begin
         if (lost_frames_ff != LostMax) begin
            lost_frames_in = lost_frames_ff + LostW'(1);
         end
         if (phase_inc >= {1'b0, det_per}) begin
            attempt_phase_in = '0;
            res.attempt_made = 1'b1;
            if (candidate_found) begin
               res.relocked = 1'b1;
               low_run_in   = pat - CountW'(1);
               st           = TRK_UNSTABLE;
            end
         end else begin
            attempt_phase_in = phase_inc[CountW-1:0];
         end
      end

      res.track_state = st;
      res.lost_count  = lost_frames_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_run_ff       <= '0;
         check_counter_ff <= '0;
         drift_latch_ff   <= 1'b0;
         lost_frames_ff   <= '0;
         attempt_phase_ff <= '0;
      end else if (step) begin
         low_run_ff       <= low_run_in;
         check_counter_ff <= check_counter_in;
         drift_latch_ff   <= drift_latch_in;
         lost_frames_ff   <= lost_frames_in;
         attempt_phase_ff <= attempt_phase_in;
      end
   end

   assign result = res;

endmodule

FILE: design/track_health_supervisor.sv
`timescale 1ns / 1ps
// Track health supervisor: one request per video frame carries the tracker
// score, the appearance similarity and the candidate-found flag; one response
// comes back per request with the track state, the drift-check and
// re-acquisition event flags and the saturating lost-frame count.
// Channels are valid/ready: req_bus in, rsp_bus out, csr_bus for register
// writes (index 0..5 as listed, other indexes ignored). Registers must be
// written by the user only while no request is in flight; the block itself
// does not enforce it. A request moves from the request register through
// the counter update into the response register. Throughput is one request
// per cycle while the receiver does not stall, set by the combinational
// update of the per-track counters between the two registers.
// When the receiver stalls, the response holds in its register and one more
// request can be taken into the request register; ready then drops until
// the response leaves.
// Reset (synchronous, active high) clears all counters and latches, restores
// the register defaults and empties both stages; ready is low during reset.
`include "track_health_supervisor_defines.svh"
module track_health_supervisor import ths_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ths_req_if.sink   req_bus,
   ths_rsp_if.source rsp_bus,
   ths_csr_if.sink   csr_bus
);

   logic                   in_valid_ff, in_valid_in;
   logic [ScoreW-1:0]      in_score_ff;
   logic signed [SimW-1:0] in_sim_ff;
   logic                   in_cand_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   ths_rsp_type            rsp_data_ff;

   logic        advance;
   logic        req_take;
   ths_cfg_type cfg;
   ths_rsp_type result;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !reset && (!in_valid_ff || advance);
   assign req_take       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready  = !reset;
   assign in_valid_in    = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_bus.ready);

   ths_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid && csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   ths_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .step            (advance),
      .score           (in_score_ff),
      .similarity      (in_sim_ff),
      .candidate_found (in_cand_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         in_score_ff <= req_bus.score;
         in_sim_ff   <= req_bus.similarity;
         in_cand_ff  <= req_bus.candidate_found;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.track_state   = rsp_data_ff.track_state;
   assign rsp_bus.drift_checked = rsp_data_ff.drift_checked;
   assign rsp_bus.drift_failed  = rsp_data_ff.drift_failed;
   assign rsp_bus.attempt_made  = rsp_data_ff.attempt_made;
   assign rsp_bus.relocked      = rsp_data_ff.relocked;
   assign rsp_bus.lost_count    = rsp_data_ff.lost_count;

   // a relock only comes out of an attempt and leaves the track on probation
   `THS_ASSERT_IMP(a_relock_attempt, clock, reset, rsp_valid_ff && rsp_data_ff.relocked,
      rsp_data_ff.attempt_made && rsp_data_ff.track_state == TRK_UNSTABLE,
      "relock without attempt or not unstable")
   // a failed drift check was a check and forced loss, unless an attempt relocked at once
   `THS_ASSERT_IMP(a_drift_fail_lost, clock, reset, rsp_valid_ff && rsp_data_ff.drift_failed,
      rsp_data_ff.drift_checked &&
      (rsp_data_ff.track_state == TRK_LOST || rsp_data_ff.relocked),
      "drift failure without check")
   // every request that leaves the input stage lands in the response register
   `THS_ASSERT_NXT(a_advance_lands, clock, reset, advance, rsp_valid_ff,
      "processed request did not reach response register")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import ths_pkg::*;

   localparam int Phases       = 16;
   localparam int LongPhase    = 8;
   localparam int PhaseFrames  = 36;
   localparam int LongFrames   = 280;
   localparam int MaxGap       = 17;
   localparam int ReportLimit  = 10;
   localparam logic [CsrIdxW-1:0] RegUnmappedLo = 3'd6;
   localparam logic [CsrIdxW-1:0] RegUnmappedHi = 3'd7;

   // per-frame prediction of the supervisor, with its own copy of the settings
   class health_predictor;
      logic [ScoreW-1:0]      score_thr;
      logic [CountW-1:0]      patience;
      logic [CountW-1:0]      drift_per;
      logic signed [SimW-1:0] sim_limit;
      logic [CountW-1:0]      detect_per;
      logic                   reacq_en;

      logic [CountW-1:0] low_run;
      logic [CountW-1:0] check_count;
      logic              drift_latch;
      logic [LostW-1:0]  lost_frames;
      logic [CountW-1:0] attempt_phase;

      ths_rsp_type expected_frames[$];
      int unsigned requests, responses, drift_checks, drift_fails, attempts, relocks, errors;

      function new();
         score_thr     = ScoreThrReset;
         patience      = PatienceReset;
         drift_per     = DriftPerReset;
         sim_limit     = DriftThrReset;
         detect_per    = DetectPerReset;
         reacq_en      = ReacqEnReset;
         low_run       = '0;
         check_count   = '0;
         drift_latch   = 1'b0;
         lost_frames   = '0;
         attempt_phase = '0;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= ReportLimit) $display("ERROR: %s", what);
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDatW-1:0] value);
         case (ths_reg_type'(idx))
            REG_SCORE_THRESHOLD:  score_thr  = value[ScoreW-1:0];
            REG_LOSS_PATIENCE:    patience   = value[CountW-1:0];
            REG_DRIFT_PERIOD:     drift_per  = value[CountW-1:0];
            REG_DRIFT_THRESHOLD:  sim_limit  = value[SimW-1:0];
            REG_DETECT_PERIOD:    detect_per = value[CountW-1:0];
            REG_REACQUIRE_ENABLE: reacq_en   = value[0];
            default: ;
         endcase
      endfunction

      function void note_frame(logic [ScoreW-1:0] score, logic signed [SimW-1:0] sim,
                               logic cand);
         logic [CountW-1:0] pat;
         logic [CountW-1:0] per;
         logic              due;
         ths_rsp_type       want;
         want = '0;
         due  = 1'b0;
         pat  = (patience == '0) ? 8'd1 : patience;
         per  = (detect_per == '0) ? 8'd1 : detect_per;

         if (score < score_thr) begin
            if (low_run != CountMax) low_run++;
         end else begin
            low_run = '0;
         end
         if (low_run == '0) want.track_state = TRK_TRACKING;
         else if (low_run >= pat) want.track_state = TRK_LOST;
         else want.track_state = TRK_UNSTABLE;

         if (want.track_state == TRK_TRACKING) begin
            if (drift_per != '0) begin
               // a failed check is retried on every tracking frame until it passes
               if (drift_latch) begin
                  due = 1'b1;
               end else begin
                  if (check_count != CountMax) check_count++;
                  due = (check_count >= drift_per);
               end
            end
            if (due) begin
               want.drift_checked = 1'b1;
               check_count = '0;
               if (sim >= sim_limit) begin
                  drift_latch = 1'b0;
               end else begin
                  drift_latch       = 1'b1;
                  want.drift_failed = 1'b1;
                  low_run           = pat;
                  want.track_state  = TRK_LOST;
               end
            end
            if (want.track_state == TRK_TRACKING) begin
               lost_frames   = '0;
               attempt_phase = '0;
            end
         end

         if (want.track_state == TRK_LOST && reacq_en) begin
            if (lost_frames != LostMax) lost_frames++;
            // the phase never rests above 254, so the increment cannot wrap
            attempt_phase++;
            if (attempt_phase >= per) begin
               attempt_phase     = '0;
               want.attempt_made = 1'b1;
               if (cand) begin
                  want.relocked    = 1'b1;
                  low_run          = pat - 1'b1;
                  want.track_state = TRK_UNSTABLE;
               end
            end
         end
         want.lost_count = lost_frames;

         requests++;
         drift_checks += want.drift_checked;
         drift_fails  += want.drift_failed;
         attempts     += want.attempt_made;
         relocks      += want.relocked;
         expected_frames.push_back(want);
      endfunction

      function void check_frame(ths_rsp_type got);
         ths_rsp_type want;
         if (expected_frames.size() == 0) begin
            flag($sformatf("response with no request outstanding: state=%0d lost=%0d",
                           got.track_state, got.lost_count));
            return;
         end
         want = expected_frames.pop_front();
         responses++;
         if (got.track_state !== want.track_state || got.drift_checked !== want.drift_checked ||
             got.drift_failed !== want.drift_failed || got.attempt_made !== want.attempt_made ||
             got.relocked !== want.relocked || got.lost_count !== want.lost_count)
            flag($sformatf({"response %0d: expected state=%0d chk=%b fail=%b att=%b rel=%b ",
                            "lost=%0d, got state=%0d chk=%b fail=%b att=%b rel=%b lost=%0d"},
                           responses, want.track_state, want.drift_checked, want.drift_failed,
                           want.attempt_made, want.relocked, want.lost_count,
                           got.track_state, got.drift_checked, got.drift_failed,
                           got.attempt_made, got.relocked, got.lost_count));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   gaps_on = 1'b1;
   int   reg_writes = 0;
   health_predictor health;

   ths_req_if req_if ();
   ths_rsp_if rsp_if ();
   ths_csr_if csr_if ();

   track_health_supervisor u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, MaxGap) : 0;
   endfunction

   // one of the two extremes, or more often a value from the busy low end
   function automatic int pick(int lo, int hi, int top);
      case ($urandom_range(0, 4))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, top);
      endcase
   endfunction

   task automatic send_frame(input logic [ScoreW-1:0] score,
                             input logic signed [SimW-1:0] sim, input logic cand);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.score           <= score;
      req_if.similarity      <= sim;
      req_if.candidate_found <= cand;
      do @(posedge clock); while (!req_if.ready);
      health.note_frame(score, sim, cand);
   endtask

   // leaves valid high between back-to-back writes; the caller drops it afterwards
   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDatW-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      health.write_reg(idx, value);
      reg_writes++;
   endtask

   task automatic drain_frames();
      while (health.expected_frames.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_phase(input int phase);
      logic [CsrDatW-1:0] junk;
      int dthr;
      junk = 16'($urandom);
      dthr = pick(0, 32768, 32768) - 16384;
      if ($urandom_range(0, 7) == 0) dthr = $urandom;
      csr_write(REG_SCORE_THRESHOLD, (phase == LongPhase) ? 16'hFFFF : 16'(pick(0, 65535, 65535)));
      csr_write(REG_LOSS_PATIENCE,
                {junk[15:8], (phase == LongPhase) ? 8'hFF : 8'(pick(0, 255, 8))});
      csr_write(REG_DRIFT_PERIOD, {junk[7:0], 8'(pick(0, 255, 6))});
      csr_write(REG_DRIFT_THRESHOLD, 16'(dthr));
      csr_write(REG_DETECT_PERIOD, {junk[11:4], 8'(pick(0, 255, 6))});
      csr_write(REG_REACQUIRE_ENABLE,
                {junk[15:1], (phase == LongPhase) || ($urandom_range(0, 3) != 0)});
      if ($urandom_range(0, 1))
         csr_write($urandom_range(0, 1) ? RegUnmappedHi : RegUnmappedLo, ~junk);
      csr_if.valid <= 1'b0;
   endtask

   // bursts of good, low, boundary and random scores so the track walks
   // through every state; similarity sits on the threshold edge half of the time
   task automatic run_phase(input int count, input bit long_run);
      int kind;
      int left;
      int thr;
      logic [ScoreW-1:0]      score;
      logic signed [SimW-1:0] sim;
      kind = 0;
      left = 0;
      thr  = int'(health.score_thr);
      for (int n = 0; n < count; n++) begin
         if (left == 0) begin
            kind = long_run ? 1 : $urandom_range(0, 4);
            left = long_run ? count : $urandom_range(1, 10);
         end
         left--;
         if (long_run && $urandom_range(0, 19) == 0) kind = 2;
         case (kind)
            1: score = (thr == 0) ? 16'd0 : 16'($urandom_range(0, thr - 1));
            2: score = 16'($urandom);
            3: score = 16'(thr - int'($urandom_range(0, 1)));
            default: score = 16'($urandom_range(thr, 65535));
         endcase
         if (long_run) kind = 1;
         case ($urandom_range(0, 3))
            0: sim = health.sim_limit;
            1: sim = health.sim_limit - 16'sd1;
            2: sim = 16'($urandom);
            default: sim = 16'($urandom_range(0, 32768) - 16384);
         endcase
         send_frame(score, sim, 1'($urandom_range(0, 1)));
      end
      req_if.valid <= 1'b0;
   endtask

   initial begin : response_side
      ths_rsp_type got;
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.track_state   = rsp_if.track_state;
         got.drift_checked = rsp_if.drift_checked;
         got.drift_failed  = rsp_if.drift_failed;
         got.attempt_made  = rsp_if.attempt_made;
         got.relocked      = rsp_if.relocked;
         got.lost_count    = rsp_if.lost_count;
         health.check_frame(got);
      end
   end

   initial begin
      health = new();
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.score           <= '0;
      req_if.similarity      <= '0;
      req_if.candidate_found <= 1'b0;
      rsp_if.ready           <= 1'b0;
      csr_if.valid           <= 1'b0;
      csr_if.index           <= '0;
      csr_if.data            <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: score edges, five low scores to loss, no re-acquisition
      send_frame(16'hFFFF, 16'sh4000, 1'b0);
      send_frame(16'd2048, 16'sh8000, 1'b1);
      send_frame(16'd2047, 16'sh7FFF, 1'b1);
      send_frame(16'd0, 16'sh0000, 1'b0);
      send_frame(16'd1, 16'shFFFF, 1'b1);
      send_frame(16'd0, 16'sh0000, 1'b0);
      send_frame(16'd0, 16'sh0000, 1'b1);
      send_frame(16'd0, 16'sh7FFF, 1'b1);
      send_frame(16'hFFFF, 16'shC000, 1'b0);
      req_if.valid <= 1'b0;
      drain_frames();

      // zero patience and zero detect period, written with junk above the field
      csr_write(REG_SCORE_THRESHOLD, 16'h8000);
      csr_write(REG_LOSS_PATIENCE, 16'h1100);
      csr_write(REG_DRIFT_PERIOD, 16'h0201);
      csr_write(REG_DRIFT_THRESHOLD, 16'h0000);
      csr_write(REG_DETECT_PERIOD, 16'h0400);
      csr_write(REG_REACQUIRE_ENABLE, 16'hFFFF);
      csr_if.valid <= 1'b0;
      send_frame(16'hFFFF, 16'sh0000, 1'b0);
      send_frame(16'h8000, 16'shFFFF, 1'b0);
      send_frame(16'h7FFF, 16'sh0005, 1'b1);
      send_frame(16'hFFFF, 16'shFFFB, 1'b0);
      send_frame(16'hFFFF, 16'sh0001, 1'b0);
      req_if.valid <= 1'b0;
      drain_frames();

      // long periods, then shortened below the running counters
      csr_write(REG_LOSS_PATIENCE, 16'd3);
      csr_write(REG_DRIFT_PERIOD, 16'd255);
      csr_write(REG_DRIFT_THRESHOLD, 16'hC000);
      csr_write(REG_DETECT_PERIOD, 16'd255);
      csr_if.valid <= 1'b0;
      repeat (4) send_frame(16'hFFFF, 16'sh8000, 1'b1);
      req_if.valid <= 1'b0;
      drain_frames();
      csr_write(REG_DRIFT_PERIOD, 16'd2);
      csr_if.valid <= 1'b0;
      send_frame(16'hFFFF, 16'shC000, 1'b0);
      send_frame(16'hFFFF, 16'sh8000, 1'b0);
      send_frame(16'hFFFF, 16'shBFFF, 1'b0);
      repeat (3) send_frame(16'd0, 16'sh0000, 1'b1);
      req_if.valid <= 1'b0;
      drain_frames();
      csr_write(REG_DETECT_PERIOD, 16'd2);
      csr_if.valid <= 1'b0;
      send_frame(16'd0, 16'sh0000, 1'b1);
      req_if.valid <= 1'b0;

      for (int phase = 0; phase < Phases; phase++) begin
         drain_frames();
         program_phase(phase);
         gaps_on = (phase % 3 != 2);
         run_phase((phase == LongPhase) ? LongFrames : PhaseFrames, phase == LongPhase);
      end

      while (health.expected_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests and %0d responses checked, %0d register writes",
               health.requests, health.responses, reg_writes);
      $display("events: %0d drift checks (%0d failed), %0d attempts (%0d relocked), %0d errors",
               health.drift_checks, health.drift_fails, health.attempts, health.relocks,
               health.errors);
      if (health.errors == 0 && health.expected_frames.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/ths_pkg.sv
design/ths_if.sv
design/ths_csr.sv
design/ths_core.sv
design/track_health_supervisor.sv
bench/tb.sv
